/* sv/edmt_pkg.sv */
// edmt_pkg: shared constants, control word types and the microcode rom
// for the egg drop minimum trials block; depends on nothing
`default_nettype none

package edmt_pkg;

  // built bounds
  localparam int MAX_EGGS   = 8;
  localparam int MAX_FLOORS = 256;

  // field widths
  localparam int EGGS_W   = 4;
  localparam int FLOORS_W = 9;
  localparam int DROP_W   = 9;

  // row storage and counters
  localparam int ROW_DEPTH = MAX_FLOORS + 1;
  localparam int ADDR_W    = $clog2(ROW_DEPTH);
  localparam int CNT_W     = $clog2(MAX_FLOORS + 2);
  localparam int EGG_CNT_W = $clog2(MAX_EGGS + 2);
  localparam int PC_W      = 4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SETUP,
    OP_INIT_WR,
    OP_CUR0,
    OP_CUR1,
    OP_FTOP,
    OP_READ,
    OP_STORE,
    OP_SWAP,
    OP_RES_RD,
    OP_RES_OUT,
    OP_BAD_OUT
  } dp_op_t;

  typedef enum logic [2:0] {
    J_NEXT,
    J_ALWAYS,
    J_NO_START,
    J_BAD,
    J_F_NE_N,
    J_E_GT,
    J_F_GT,
    J_X_NE_F
  } jump_cond_t;

  typedef struct packed {
    dp_op_t            op;
    jump_cond_t        cond;
    logic [PC_W-1:0]   target;
  } uword_t;

  typedef struct packed {
    logic bad;
    logic f_ne_n;
    logic e_gt;
    logic f_gt;
    logic x_ne_f;
  } dp_flags_t;

  // microprogram step addresses
  localparam logic [PC_W-1:0] PC_IDLE    = PC_W'(0);
  localparam logic [PC_W-1:0] PC_SETUP   = PC_W'(1);
  localparam logic [PC_W-1:0] PC_INIT    = PC_W'(2);
  localparam logic [PC_W-1:0] PC_EGG     = PC_W'(3);
  localparam logic [PC_W-1:0] PC_CUR1    = PC_W'(4);
  localparam logic [PC_W-1:0] PC_FTOP    = PC_W'(5);
  localparam logic [PC_W-1:0] PC_READ    = PC_W'(6);
  localparam logic [PC_W-1:0] PC_DRAIN   = PC_W'(7);
  localparam logic [PC_W-1:0] PC_STORE   = PC_W'(8);
  localparam logic [PC_W-1:0] PC_SWAP    = PC_W'(9);
  localparam logic [PC_W-1:0] PC_RES_RD  = PC_W'(10);
  localparam logic [PC_W-1:0] PC_RES_OUT = PC_W'(11);
  localparam logic [PC_W-1:0] PC_BAD     = PC_W'(12);

  // microcode rom: one control word per step
  function automatic uword_t ucode_word(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NONE, cond: J_ALWAYS, target: PC_IDLE};
    unique case (pc)
      PC_IDLE:    w = '{op: OP_LATCH,   cond: J_NO_START, target: PC_IDLE};
      PC_SETUP:   w = '{op: OP_SETUP,   cond: J_BAD,      target: PC_BAD};
      PC_INIT:    w = '{op: OP_INIT_WR, cond: J_F_NE_N,   target: PC_INIT};
      PC_EGG:     w = '{op: OP_CUR0,    cond: J_E_GT,     target: PC_RES_RD};
      PC_CUR1:    w = '{op: OP_CUR1,    cond: J_NEXT,     target: PC_IDLE};
      PC_FTOP:    w = '{op: OP_FTOP,    cond: J_F_GT,     target: PC_SWAP};
      PC_READ:    w = '{op: OP_READ,    cond: J_X_NE_F,   target: PC_READ};
      PC_DRAIN:   w = '{op: OP_NONE,    cond: J_NEXT,     target: PC_IDLE};
      PC_STORE:   w = '{op: OP_STORE,   cond: J_ALWAYS,   target: PC_FTOP};
      PC_SWAP:    w = '{op: OP_SWAP,    cond: J_ALWAYS,   target: PC_EGG};
      PC_RES_RD:  w = '{op: OP_RES_RD,  cond: J_NEXT,     target: PC_IDLE};
      PC_RES_OUT: w = '{op: OP_RES_OUT, cond: J_ALWAYS,   target: PC_IDLE};
      PC_BAD:     w = '{op: OP_BAD_OUT, cond: J_ALWAYS,   target: PC_IDLE};
      default:    w = '{op: OP_NONE,    cond: J_ALWAYS,   target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* sv/edmt_row_ram.sv */
// edmt_row_ram: one row of drop counts, one write port and one registered
// read port; depends on edmt_pkg
`default_nettype none

module edmt_row_ram (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [edmt_pkg::ADDR_W-1:0] waddr,
  input  wire logic [edmt_pkg::DROP_W-1:0] wdata,
  input  wire logic [edmt_pkg::ADDR_W-1:0] raddr,
  output      logic [edmt_pkg::DROP_W-1:0] rdata
);
  import edmt_pkg::*;

  logic [DROP_W-1:0] mem [ROW_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/edmt_seq.sv */
// edmt_seq: step counter, microcode fetch and conditional jumps
// depends on edmt_pkg
`default_nettype none

module edmt_seq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire edmt_pkg::dp_flags_t flags,
  output      edmt_pkg::dp_op_t    op,
  output      logic                busy
);
  import edmt_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  uword_t          w;
  logic            take;

  assign w    = ucode_word(pc);
  assign op   = w.op;
  assign busy = (pc != PC_IDLE);

  always_comb begin
    unique case (w.cond)
      J_NEXT:     take = 1'b0;
      J_ALWAYS:   take = 1'b1;
      J_NO_START: take = !start;
      J_BAD:      take = flags.bad;
      J_F_NE_N:   take = flags.f_ne_n;
      J_E_GT:     take = flags.e_gt;
      J_F_GT:     take = flags.f_gt;
      J_X_NE_F:   take = flags.x_ne_f;
      default:    take = 1'b1;
    endcase
    pc_next = take ? w.target : pc + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

/* sv/edmt_dp.sv */
// edmt_dp: counters, min/max compare unit, two ping-pong row memories and
// result registers; depends on edmt_pkg and edmt_row_ram
`default_nettype none

module edmt_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire edmt_pkg::dp_op_t             op,
  input  wire logic [edmt_pkg::EGGS_W-1:0]   eggs,
  input  wire logic [edmt_pkg::FLOORS_W-1:0] floors,
  output      edmt_pkg::dp_flags_t          flags,
  output      logic                         done,
  output      logic [edmt_pkg::DROP_W-1:0]   min_drops,
  output      logic                         bad_request
);
  import edmt_pkg::*;

  logic [EGGS_W-1:0]    eggs_q;
  logic [FLOORS_W-1:0]  floors_q;
  logic                 bad_q;
  logic [CNT_W-1:0]     f;
  logic [CNT_W-1:0]     x;
  logic [EGG_CNT_W-1:0] e;
  logic                 bank;
  logic [DROP_W:0]      best;
  logic                 rd_valid;

  logic                 bad_in;
  logic                 wr_en;
  logic                 wr_cur;
  logic [ADDR_W-1:0]    wr_addr;
  logic [DROP_W-1:0]    wr_data;
  logic [CNT_W-1:0]     x_m1;
  logic [CNT_W-1:0]     f_mx;
  logic [ADDR_W-1:0]    prev_raddr;
  logic [ADDR_W-1:0]    cur_raddr;
  logic [DROP_W-1:0]    prev_rdata;
  logic [DROP_W-1:0]    cur_rdata;
  logic [DROP_W-1:0]    larger;
  logic [DROP_W:0]      cand;

  logic                 a_we, b_we;
  logic [ADDR_W-1:0]    a_raddr, b_raddr;
  logic [DROP_W-1:0]    a_rdata, b_rdata;

  assign bad_in = (eggs == '0) || (floors == '0) ||
                  (32'(eggs) > 32'(MAX_EGGS)) || (32'(floors) > 32'(MAX_FLOORS));

  assign flags.bad    = bad_q;
  assign flags.f_ne_n = (32'(f) != 32'(floors_q));
  assign flags.e_gt   = (32'(e) > 32'(eggs_q));
  assign flags.f_gt   = (32'(f) > 32'(floors_q));
  assign flags.x_ne_f = (x != f);

  // write port: init of the previous row or a cell of the current row
  always_comb begin
    wr_en   = 1'b0;
    wr_cur  = 1'b1;
    wr_addr = '0;
    wr_data = '0;
    unique case (op)
      OP_INIT_WR: begin
        wr_en   = 1'b1;
        wr_cur  = 1'b0;
        wr_addr = f[ADDR_W-1:0];
        wr_data = DROP_W'(f);
      end
      OP_CUR0: begin
        wr_en   = 1'b1;
      end
      OP_CUR1: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(1);
        wr_data = DROP_W'(1);
      end
      OP_STORE: begin
        wr_en   = 1'b1;
        wr_addr = f[ADDR_W-1:0];
        wr_data = best[DROP_W-1:0];
      end
      default: begin
        wr_en   = 1'b0;
      end
    endcase
  end

  // bank 0: previous row in a, current row in b
  assign a_we = wr_en && (wr_cur == bank);
  assign b_we = wr_en && (wr_cur != bank);

  assign x_m1       = x - CNT_W'(1);
  assign f_mx       = f - x;
  assign prev_raddr = (op == OP_RES_RD) ? ADDR_W'(floors_q) : x_m1[ADDR_W-1:0];
  assign cur_raddr  = f_mx[ADDR_W-1:0];
  assign a_raddr    = bank ? cur_raddr : prev_raddr;
  assign b_raddr    = bank ? prev_raddr : cur_raddr;
  assign prev_rdata = bank ? b_rdata : a_rdata;
  assign cur_rdata  = bank ? a_rdata : b_rdata;

  assign larger = (prev_rdata > cur_rdata) ? prev_rdata : cur_rdata;
  assign cand   = {1'b0, larger} + (DROP_W+1)'(1);

  edmt_row_ram u_row_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  edmt_row_ram u_row_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      done     <= (op == OP_RES_OUT) || (op == OP_BAD_OUT);
      rd_valid <= (op == OP_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid && (cand < best)) begin
      best <= cand;
    end
    unique case (op)
      OP_LATCH: begin
        eggs_q   <= eggs;
        floors_q <= floors;
        bad_q    <= bad_in;
      end
      OP_SETUP: begin
        f    <= '0;
        e    <= EGG_CNT_W'(2);
        bank <= 1'b0;
      end
      OP_INIT_WR: f <= f + CNT_W'(1);
      OP_CUR1:    f <= CNT_W'(2);
      OP_FTOP: begin
        x    <= CNT_W'(1);
        best <= '1;
      end
      OP_READ:    x <= x + CNT_W'(1);
      OP_STORE:   f <= f + CNT_W'(1);
      OP_SWAP: begin
        bank <= ~bank;
        e    <= e + EGG_CNT_W'(1);
      end
      OP_RES_OUT: begin
        min_drops   <= prev_rdata;
        bad_request <= 1'b0;
      end
      OP_BAD_OUT: begin
        min_drops   <= '0;
        bad_request <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/egg_drop_min_trials.sv */
// egg_drop_min_trials: top level, microcoded sequencer plus datapath
// depends on edmt_pkg, edmt_seq and edmt_dp
//
// channel   ports                    transfer
// request   start, eggs, floors      start high while busy low
// result    done, min_drops,         done high for one cycle, no stall
//           bad_request
//
// flow: a rejected request passes the setup and bad-result steps before done;
// a good one writes the first row, then computes one row per extra egg,
// the inner compare loop issuing one pair of row reads per cycle, and
// reads the result for all floors from the last row
// reset: synchronous active-high rst returns the step counter to idle; the
// row memories are not cleared, every entry is written before it is read
// stalls: the receiver cannot stall; busy stays high from the cycle after a
// transfer and drops in the cycle in which done rises
`default_nettype none

module egg_drop_min_trials (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [edmt_pkg::EGGS_W-1:0]   eggs,
  input  wire logic [edmt_pkg::FLOORS_W-1:0] floors,
  output      logic                         busy,
  output      logic                         done,
  output      logic [edmt_pkg::DROP_W-1:0]   min_drops,
  output      logic                         bad_request
);
  import edmt_pkg::*;

  // control word operation from the rom to the datapath
  dp_op_t    op;
  // loop and check flags back to the jump logic
  dp_flags_t flags;

  // sequencer: program counter walks the microcode rom
  edmt_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .op    (op),
    .busy  (busy)
  );

  // datapath: counters, compare unit and the two ping-pong rows
  edmt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .eggs        (eggs),
    .floors      (floors),
    .flags       (flags),
    .done        (done),
    .min_drops   (min_drops),
    .bad_request (bad_request)
  );

  // result strobe only shows once the sequencer is back at idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // a request transfer always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("no busy after request transfer");

  // done follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without preceding work");

  // a rejected request reports zero drops
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (done && bad_request) |-> (min_drops == '0))
    else $error("rejected request with nonzero drops");

  // a good request needs at least one drop
  a_good_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && !bad_request) |-> (min_drops != '0))
    else $error("good request with zero drops");

endmodule

`default_nettype wire
